/* rtl/core/drorq_pkg.sv */
// Shared constants and types for the two-reader overwriting report ring.
package drorq_pkg;

  // Default number of report slots in the ring
  localparam int unsigned DefaultCapacity = 16;

  // Report field widths
  localparam int unsigned ModW   = 8;
  localparam int unsigned KeysW  = 48;
  localparam int unsigned EntryW = ModW + KeysW;

  // Sequence, drop counter and reported count widths
  localparam int unsigned SeqW   = 32;
  localparam int unsigned CountW = 5;

  // Number of independent readers
  localparam int unsigned NumReaders = 2;

  // Operation selector
  typedef enum logic [1:0] {
    FUNC_PUSH         = 2'd0,
    FUNC_DRAIN_FIRST  = 2'd1,
    FUNC_DRAIN_SECOND = 2'd2
  } func_e;

endpackage

/* rtl/core/dual_reader_overwrite_ring_queue_core.sv */
// Two-reader overwriting ring of keyboard reports, with drop counters and peak level.
//
// A ring of CAPACITY keyboard reports (modifier byte plus six key bytes) that is fed by
// pushes and read by two independent readers. A push always succeeds. When a reader's
// backlog would exceed CAPACITY, that reader skips its oldest entry and its 32-bit
// wrapping drop counter advances. A drain returns the reader's next report, or
// got_report_o low when nothing is pending. Every result word also shows both pending
// counts, both drop counters and the highest pending count seen after any push. A new
// word is accepted every cycle unless a result waits untaken: the state update is a
// single pass of counter logic, and the one ring read goes through the registered read
// port of the store. The result register frees itself in the same cycle that its word
// is taken. Slot indices follow sequence mod CAPACITY, including the jump at the 32-bit
// sequence wrap. No clearing pass runs after reset, because a reader only ever reads
// slots that were pushed before.
module dual_reader_overwrite_ring_queue_core #(
  parameter int unsigned CAPACITY = drorq_pkg::DefaultCapacity
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // input words
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [1:0]                  func_i,
  input  logic [drorq_pkg::ModW-1:0]  in_modifiers_i,
  input  logic [drorq_pkg::KeysW-1:0] in_keys_i,
  // result words
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        got_report_o,
  output logic [drorq_pkg::ModW-1:0]  out_modifiers_o,
  output logic [drorq_pkg::KeysW-1:0] out_keys_o,
  output logic [drorq_pkg::CountW-1:0] pending_first_o,
  output logic [drorq_pkg::CountW-1:0] pending_second_o,
  output logic [drorq_pkg::SeqW-1:0]  drops_first_o,
  output logic [drorq_pkg::SeqW-1:0]  drops_second_o,
  output logic [drorq_pkg::CountW-1:0] peak_pending_o
);

  localparam int unsigned SlotW = $clog2(CAPACITY);
  localparam int unsigned LvlW  = $clog2(CAPACITY + 1);
  localparam int unsigned SeqW  = drorq_pkg::SeqW;
  localparam int unsigned NR    = drorq_pkg::NumReaders;
  localparam logic [SeqW-1:0]  Cap32    = SeqW'(CAPACITY);
  localparam logic [SlotW-1:0] LastSlot = SlotW'(CAPACITY - 1);
  localparam logic [SeqW-1:0]  SeqMax   = {SeqW{1'b1}};

  // Slot that follows a sequence: wraps at CAPACITY and restarts at the sequence wrap
  function automatic logic [SlotW-1:0] next_slot(input logic [SeqW-1:0]  seq,
                                                 input logic [SlotW-1:0] slot);
    logic [SlotW-1:0] res;
    if (seq == SeqMax || slot == LastSlot) begin
      res = '0;
    end else begin
      res = slot + SlotW'(1);
    end
    return res;
  endfunction

  // Report store
  logic [drorq_pkg::EntryW-1:0] store_mem [CAPACITY];
  logic [drorq_pkg::EntryW-1:0] rdata_q;

  // Ring state
  logic [SeqW-1:0]  wseq_q, wseq_d;
  logic [SlotW-1:0] wslot_q, wslot_d;
  logic [SeqW-1:0]  rseq_q [NR];
  logic [SeqW-1:0]  rseq_d [NR];
  logic [SlotW-1:0] rslot_q [NR];
  logic [SlotW-1:0] rslot_d [NR];
  logic [SeqW-1:0]  drops_q [NR];
  logic [SeqW-1:0]  drops_d [NR];
  logic [LvlW-1:0]  peak_q, peak_d;

  // Result register
  logic out_valid_q;
  logic got_q, got_d;

  logic             in_fire;
  logic             mem_we;
  logic             rd_idx;
  logic [SeqW-1:0]  lag [NR];
  logic [SeqW-1:0]  pend [NR];
  logic [SeqW-1:0]  hi;
  logic [SeqW-1:0]  pend_out [NR];
  logic [SeqW-1:0]  peak_wide;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;
  assign rd_idx     = (func_i == drorq_pkg::FUNC_DRAIN_SECOND);

  // Next state for one word
  always_comb begin
    wseq_d  = wseq_q;
    wslot_d = wslot_q;
    rseq_d  = rseq_q;
    rslot_d = rslot_q;
    drops_d = drops_q;
    peak_d  = peak_q;
    got_d   = got_q;
    mem_we  = 1'b0;
    for (int r = 0; r < NR; r++) begin
      lag[r]  = (wseq_q + SeqW'(1)) - rseq_q[r];
      pend[r] = (lag[r] > Cap32) ? Cap32 : lag[r];
    end
    hi = (pend[0] > pend[1]) ? pend[0] : pend[1];

    if (in_fire) begin
      got_d = 1'b0;
      unique case (drorq_pkg::func_e'(func_i))
        drorq_pkg::FUNC_PUSH: begin
          // write the slot, then push lagging readers past the overwritten entry
          mem_we  = 1'b1;
          wseq_d  = wseq_q + SeqW'(1);
          wslot_d = next_slot(wseq_q, wslot_q);
          for (int r = 0; r < NR; r++) begin
            if (lag[r] > Cap32) begin
              rseq_d[r]  = rseq_q[r] + SeqW'(1);
              rslot_d[r] = next_slot(rseq_q[r], rslot_q[r]);
              drops_d[r] = drops_q[r] + SeqW'(1);
            end
          end
          if (hi > SeqW'(peak_q)) begin
            peak_d = hi[LvlW-1:0];
          end
        end
        drorq_pkg::FUNC_DRAIN_FIRST, drorq_pkg::FUNC_DRAIN_SECOND: begin
          // advance the reader when something is pending
          if (wseq_q != rseq_q[rd_idx]) begin
            got_d           = 1'b1;
            rseq_d[rd_idx]  = rseq_q[rd_idx] + SeqW'(1);
            rslot_d[rd_idx] = next_slot(rseq_q[rd_idx], rslot_q[rd_idx]);
          end
        end
        default: begin
          got_d = 1'b0;
        end
      endcase
    end
  end

  // Hold ring state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wseq_q      <= '0;
      wslot_q     <= '0;
      peak_q      <= '0;
      got_q       <= 1'b0;
      out_valid_q <= 1'b0;
      for (int r = 0; r < NR; r++) begin
        rseq_q[r]  <= '0;
        rslot_q[r] <= '0;
        drops_q[r] <= '0;
      end
    end else begin
      wseq_q  <= wseq_d;
      wslot_q <= wslot_d;
      peak_q  <= peak_d;
      got_q   <= got_d;
      rseq_q  <= rseq_d;
      rslot_q <= rslot_d;
      drops_q <= drops_d;
      if (in_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Store write and registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      store_mem[wslot_q] <= {in_modifiers_i, in_keys_i};
    end
    if (in_fire) begin
      rdata_q <= store_mem[rslot_q[rd_idx]];
    end
  end

  // Drive the result word; counters only move when a new word loads
  always_comb begin
    for (int r = 0; r < NR; r++) begin
      pend_out[r] = wseq_q - rseq_q[r];
    end
    peak_wide = SeqW'(peak_q);
  end

  assign out_valid_o      = out_valid_q;
  assign got_report_o     = got_q;
  assign out_modifiers_o  = got_q ? rdata_q[drorq_pkg::EntryW-1:drorq_pkg::KeysW]
                                  : '0;
  assign out_keys_o       = got_q ? rdata_q[drorq_pkg::KeysW-1:0] : '0;
  assign pending_first_o  = pend_out[0][drorq_pkg::CountW-1:0];
  assign pending_second_o = pend_out[1][drorq_pkg::CountW-1:0];
  assign drops_first_o    = drops_q[0];
  assign drops_second_o   = drops_q[1];
  assign peak_pending_o   = peak_wide[drorq_pkg::CountW-1:0];

endmodule
